// ===== rtl/core/cfs_pkg.sv =====
// shared types and constants for the four-way cache set with fifo replacement
// no dependencies
package cfs_pkg;

	localparam int CFS_WAYS        = 4;
	localparam int CFS_BLOCK_BYTES = 64;
	localparam int CFS_TAG_BITS    = 8;

	// widths of the beat fields
	localparam int OP_W     = 3;
	localparam int TAG_W    = 8;
	localparam int WAY_W    = 2;
	localparam int OFFSET_W = 6;
	localparam int BYTE_W   = 8;

	// widest way index over the legal range of ways
	localparam int MAX_WAY_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 3'd0,
		OP_ALLOC = 3'd1,
		OP_WRITE = 3'd2,
		OP_QUERY = 3'd3,
		OP_INVAL = 3'd4
	} op_t;

	typedef struct packed {
		logic                 hit;
		logic [MAX_WAY_W-1:0] hit_way;
		logic [MAX_WAY_W-1:0] victim;
		logic                 qvalid;
	} dir_res_t;

endpackage

// ===== rtl/core/cfs_tag_dir.sv =====
// tag, valid and fifo pointer registers with the parallel tag compare
// depends on cfs_pkg
module cfs_tag_dir import cfs_pkg::*; #(
	parameter int WAYS     = CFS_WAYS,
	parameter int TAG_BITS = CFS_TAG_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  op_t              op,
	input  logic [TAG_W-1:0] tag,
	input  logic [WAY_W-1:0] way,
	output dir_res_t         res
);

	localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [TAG_BITS-1:0] tag_q [WAYS];
	logic [WAYS-1:0]     valid_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [TAG_BITS-1:0] tag_in;
	logic [WAYS-1:0]     match;
	logic [IDX_W-1:0]    hit_idx;
	logic                way_in_range;

	assign tag_in       = TAG_BITS'(tag);
	assign way_in_range = int'(way) < WAYS;

	always_comb begin
		hit_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = valid_q[w] && (tag_q[w] == tag_in);
			if (match[w]) begin
				hit_idx = IDX_W'(w);
			end
		end
	end

	always_comb begin
		res.hit     = |match;
		res.hit_way = MAX_WAY_W'(hit_idx);
		res.victim  = MAX_WAY_W'(ptr_q);
		res.qvalid  = way_in_range && valid_q[IDX_W'(way)];
	end

	always_ff @(posedge clk) begin
		if (upd && op == OP_ALLOC) begin
			tag_q[ptr_q] <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else if (upd) begin
			unique case (op)
				OP_ALLOC: begin
					valid_q[ptr_q] <= 1'b1;
					ptr_q          <= (int'(ptr_q) == WAYS - 1) ? '0 : ptr_q + 1'b1;
				end
				OP_INVAL: begin
					valid_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/cfs_data_mem.sv =====
// data store of the set, one write and one read port, registered read
// depends on cfs_pkg
module cfs_data_mem import cfs_pkg::*; #(
	parameter int DEPTH = CFS_WAYS * CFS_BLOCK_BYTES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [BYTE_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [BYTE_W-1:0]        rdata
);

	logic [BYTE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/four_way_cache_set_fifo.sv =====
// one set of a set-associative cache with fifo replacement
// an accepted input beat passes the first stage registers and then the result register before its result beat
// throughput: one beat per cycle while the output is not stalled, at most one data memory read or write per beat
// reset: valid bits, the fifo pointer and the stage valid flags clear, tags and data stay undefined
// depends on cfs_pkg, cfs_tag_dir and cfs_data_mem
module four_way_cache_set_fifo import cfs_pkg::*; #(
	parameter int WAYS        = CFS_WAYS,
	parameter int BLOCK_BYTES = CFS_BLOCK_BYTES,
	parameter int TAG_BITS    = CFS_TAG_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // tag, way, offset, data_byte
	input  logic [2:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // hit, way_out, read_data, way_valid, zero fill
);

	localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OFF_W  = $clog2(BLOCK_BYTES);
	localparam int DEPTH  = WAYS * BLOCK_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	op_t                 op_in;
	logic [TAG_W-1:0]    tag_in;
	logic [WAY_W-1:0]    way_in;
	logic [OFFSET_W-1:0] offset_in;
	logic [BYTE_W-1:0]   byte_in;
	logic                accept;
	logic                advance;
	dir_res_t            dir_res;
	logic [OFF_W-1:0]    off_idx;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [BYTE_W-1:0]   mem_rdata;

	logic                s1_valid_q;
	logic                hit_s1;
	logic [WAY_W-1:0]    way_s1;
	logic                qvalid_s1;

	logic                out_valid_q;
	logic                out_hit_q;
	logic [WAY_W-1:0]    out_way_q;
	logic [BYTE_W-1:0]   out_rdata_q;
	logic                out_qvalid_q;

	assign op_in     = op_t'(s_tuser);
	assign tag_in    = s_tdata[7:0];
	assign way_in    = s_tdata[9:8];
	assign offset_in = s_tdata[15:10];
	assign byte_in   = s_tdata[23:16];

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	assign off_idx   = OFF_W'(offset_in);
	assign mem_we    = accept && op_in == OP_WRITE && int'(way_in) < WAYS;
	assign mem_waddr = ADDR_W'({IDX_W'(way_in), off_idx});
	assign mem_raddr = ADDR_W'({IDX_W'(dir_res.hit_way), off_idx});

	cfs_tag_dir #(
		.WAYS     (WAYS),
		.TAG_BITS (TAG_BITS)
	) u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (accept),
		.op     (op_in),
		.tag    (tag_in),
		.way    (way_in),
		.res    (dir_res)
	);

	cfs_data_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (byte_in),
		.re    (accept && op_in == OP_READ),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1    <= 1'b0;
			way_s1    <= '0;
			qvalid_s1 <= 1'b0;
			case (op_in)
				OP_READ: begin
					hit_s1 <= dir_res.hit;
					way_s1 <= dir_res.hit ? WAY_W'(dir_res.hit_way) : '0;
				end
				OP_ALLOC: begin
					way_s1 <= WAY_W'(dir_res.victim);
				end
				OP_QUERY: begin
					qvalid_s1 <= dir_res.qvalid;
				end
				default: begin
				end
			endcase
		end
		if (advance) begin
			out_hit_q    <= hit_s1;
			out_way_q    <= way_s1;
			out_rdata_q  <= hit_s1 ? mem_rdata : '0;
			out_qvalid_q <= qvalid_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_qvalid_q, out_rdata_q, out_way_q, out_hit_q};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are full and stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted beat did not reach the first stage");

	a_miss_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_hit_q) |-> (out_rdata_q == '0))
		else $error("nonzero read data on a result without a hit");

	a_advance_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

endmodule

// ===== tb/four_way_cache_set_fifo_tb.sv =====
// testbench for four_way_cache_set_fifo: directed and random cache set accesses
// with bursty input, patterned output stalls and a scoreboard of predicted results
// depends on cfs_pkg and the four_way_cache_set_fifo rtl
`timescale 1ns / 1ps

module four_way_cache_set_fifo_tb;
	import cfs_pkg::*;

	localparam int NWAYS        = CFS_WAYS;
	localparam int NBYTES       = CFS_BLOCK_BYTES;
	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [TAG_W-1:0]    tag;
		logic [WAY_W-1:0]    way;
		logic [OFFSET_W-1:0] offset;
		logic [BYTE_W-1:0]   data_byte;
		bit                  drain;
	} access_t;

	typedef struct {
		logic             hit;
		logic [WAY_W-1:0] way_out;
		logic [7:0]       read_data;
		logic             way_valid;
	} lookup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // tag, way, offset, data_byte
	logic [2:0]  s_tuser = '0;   // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // hit, way_out, read_data, way_valid, zero fill

	four_way_cache_set_fifo u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	access_t pending_q[$];
	lookup_t lookup_q[$];
	access_t drive_item;
	int      error_count = 0;
	int      total_items = 0;
	int      beats_seen = 0;
	int      cycle_count = 0;
	int      burst_left = 8;
	int      gap_left = 0;
	int      ready_mode = 0;
	int      ready_phase = 0;

	// predictor state, updated on accepted input beats
	logic             pv_valid [NWAYS];
	logic [TAG_W-1:0] pv_tag [NWAYS];
	logic [7:0]       pv_data [NWAYS][NBYTES];
	logic [WAY_W-1:0] pv_ptr;

	// stimulus-side shadow, keeps reads away from unwritten bytes
	bit               gs_valid [NWAYS];
	logic [TAG_W-1:0] gs_tag [NWAYS];
	bit               gs_written [NWAYS][NBYTES];
	int               gs_ptr;

	initial begin
		pv_ptr = '0;
		gs_ptr = 0;
		for (int w = 0; w < NWAYS; w++) begin
			pv_valid[w] = 1'b0;
			pv_tag[w] = '0;
			gs_valid[w] = 1'b0;
			gs_tag[w] = '0;
			for (int b = 0; b < NBYTES; b++) begin
				pv_data[w][b] = '0;
				gs_written[w][b] = 1'b0;
			end
		end
	end

	function automatic lookup_t cache_set_predict(access_t a);
		lookup_t r;
		r = '{hit: 1'b0, way_out: '0, read_data: '0, way_valid: 1'b0};
		case (a.op)
			OP_READ: begin
				for (int w = NWAYS - 1; w >= 0; w--) begin
					if (pv_valid[w] && pv_tag[w] == a.tag) begin
						r.hit = 1'b1;
						r.way_out = WAY_W'(w);
						r.read_data = pv_data[w][a.offset];
					end
				end
			end
			OP_ALLOC: begin
				pv_tag[pv_ptr] = a.tag;
				pv_valid[pv_ptr] = 1'b1;
				r.way_out = pv_ptr;
				pv_ptr = pv_ptr + 1'b1;
			end
			OP_WRITE: pv_data[a.way][a.offset] = a.data_byte;
			OP_QUERY: r.way_valid = pv_valid[a.way];
			OP_INVAL: begin
				for (int w = 0; w < NWAYS; w++) pv_valid[w] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_access(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
			input logic [WAY_W-1:0] way, input logic [OFFSET_W-1:0] offset,
			input logic [BYTE_W-1:0] data_byte, input bit drain);
		access_t a;
		int      hit_way;
		hit_way = -1;
		a = '{op: op, tag: tag, way: way, offset: offset, data_byte: data_byte, drain: drain};
		case (op)
			OP_READ: begin
				for (int w = NWAYS - 1; w >= 0; w--)
					if (gs_valid[w] && gs_tag[w] == tag) hit_way = w;
				// a hit on a byte never written gets a fill write first
				if (hit_way >= 0 && !gs_written[hit_way][offset]) begin
					pending_q.push_back('{op: OP_WRITE, tag: TAG_W'($urandom), way: WAY_W'(hit_way),
						offset: offset, data_byte: BYTE_W'($urandom), drain: drain});
					gs_written[hit_way][offset] = 1'b1;
					total_items++;
					a.drain = 1'b0;
				end
			end
			OP_ALLOC: begin
				gs_tag[gs_ptr] = tag;
				gs_valid[gs_ptr] = 1'b1;
				gs_ptr = (gs_ptr + 1) % NWAYS;
			end
			OP_WRITE: gs_written[way][offset] = 1'b1;
			OP_INVAL: begin
				for (int w = 0; w < NWAYS; w++) gs_valid[w] = 1'b0;
			end
			default: ;
		endcase
		pending_q.push_back(a);
		total_items++;
	endtask

	task automatic build_directed();
		queue_access(OP_READ, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0);
		for (int w = 0; w < NWAYS; w++)
			queue_access(OP_QUERY, 8'h00, WAY_W'(w), 6'd0, 8'h00, 1'b0);
		queue_access(OP_ALLOC, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_ALLOC, 8'hFF, 2'd3, 6'd63, 8'hFF, 1'b0);
		queue_access(OP_ALLOC, 8'h5A, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_ALLOC, 8'hA5, 2'd0, 6'd0, 8'h00, 1'b0);
		// fifo wraps to way 0 with a tag also held in way 2
		queue_access(OP_ALLOC, 8'h5A, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_WRITE, 8'h00, 2'd0, 6'd0, 8'hFF, 1'b0);
		queue_access(OP_WRITE, 8'hFF, 2'd0, 6'd63, 8'h00, 1'b0);
		queue_access(OP_WRITE, 8'h00, 2'd3, 6'd63, 8'hAA, 1'b0);
		queue_access(OP_WRITE, 8'h00, 2'd1, 6'd0, 8'h55, 1'b0);
		queue_access(OP_READ, 8'h5A, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_READ, 8'h5A, 2'd3, 6'd63, 8'hFF, 1'b0);
		queue_access(OP_READ, 8'hFF, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_READ, 8'hA5, 2'd0, 6'd63, 8'h00, 1'b0);
		queue_access(OP_READ, 8'h33, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_QUERY, 8'h00, 2'd2, 6'd0, 8'h00, 1'b0);
		queue_access(OP_INVAL, 8'hFF, 2'd3, 6'd63, 8'hFF, 1'b0);
		queue_access(OP_READ, 8'h5A, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_QUERY, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0);
		// pointer survives invalidate, next victim is way 1
		queue_access(OP_ALLOC, 8'h77, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(OP_READ, 8'h77, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(3'd5, 8'hFF, 2'd3, 6'd63, 8'hFF, 1'b0);
		queue_access(3'd6, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0);
		queue_access(3'd7, 8'hFF, 2'd3, 6'd63, 8'hFF, 1'b0);
	endtask

	task automatic build_random();
		int               pick;
		int               w;
		logic [TAG_W-1:0] tag;
		bit               drain;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			drain = (i == 0) || ($urandom_range(0, 99) == 0);
			tag = TAG_W'($urandom);
			if (pick < 36) begin
				w = $urandom_range(0, NWAYS - 1);
				if ($urandom_range(0, 3) != 0 && gs_valid[w]) tag = gs_tag[w];
				queue_access(OP_READ, tag, WAY_W'($urandom), OFFSET_W'($urandom),
					BYTE_W'($urandom), drain);
			end else if (pick < 52) begin
				// small tag pool makes duplicate tags across ways
				if ($urandom_range(0, 1) == 0) tag = TAG_W'($urandom_range(0, 3) * 85);
				queue_access(OP_ALLOC, tag, WAY_W'($urandom), OFFSET_W'($urandom),
					BYTE_W'($urandom), drain);
			end else if (pick < 82) begin
				queue_access(OP_WRITE, tag, WAY_W'($urandom), OFFSET_W'($urandom),
					BYTE_W'($urandom), drain);
			end else if (pick < 91) begin
				queue_access(OP_QUERY, tag, WAY_W'($urandom), OFFSET_W'($urandom),
					BYTE_W'($urandom), drain);
			end else if (pick < 95) begin
				queue_access(OP_INVAL, tag, WAY_W'($urandom), OFFSET_W'($urandom),
					BYTE_W'($urandom), drain);
			end else begin
				queue_access(OP_W'($urandom_range(5, 7)), tag, WAY_W'($urandom),
					OFFSET_W'($urandom), BYTE_W'($urandom), drain);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	// driver: bursts with random gaps, optional drain before marked beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				lookup_q.push_back(cache_set_predict(drive_item));
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					gap_left = $urandom_range(1, 6);
					burst_left = $urandom_range(1, 40);
				end
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_q[0].drain && lookup_q.size() != 0) begin
					s_tvalid <= 1'b0;
				end else begin
					drive_item = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {drive_item.data_byte, drive_item.offset, drive_item.way,
						drive_item.tag};
					s_tuser  <= drive_item.op;
				end
			end
		end
	end

	// receiver stall pattern switches between four randomly drawn modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (ready_phase % 96 == 0) ready_mode = $urandom_range(0, 3);
			ready_phase++;
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 9) != 0);
				default: m_tready <= (ready_phase % 16 < 3);
			endcase
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (lookup_q.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 16'h0);
			end else begin
				want = lookup_q.pop_front();
				if (m_tdata[0] !== want.hit)
					report_mismatch("hit", 16'(m_tdata[0]), 16'(want.hit));
				if (m_tdata[2:1] !== want.way_out)
					report_mismatch("way_out", 16'(m_tdata[2:1]), 16'(want.way_out));
				if (m_tdata[10:3] !== want.read_data)
					report_mismatch("read_data", 16'(m_tdata[10:3]), 16'(want.read_data));
				if (m_tdata[11] !== want.way_valid)
					report_mismatch("way_valid", 16'(m_tdata[11]), 16'(want.way_valid));
				if (m_tdata[15:12] !== 4'h0)
					report_mismatch("fill bits", 16'(m_tdata[15:12]), 16'h0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** four_way_cache_set_fifo: FAILED **");
			$finish;
		end
	end

	initial begin
		build_directed();
		build_random();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (beats_seen < total_items) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (lookup_q.size() != 0) report_mismatch("missing beats", 16'(lookup_q.size()), 16'h0);
		if (error_count == 0) begin
			$display("** four_way_cache_set_fifo: PASSED **");
		end else begin
			$display("** four_way_cache_set_fifo: FAILED **");
		end
		$finish;
	end

endmodule

// ===== four_way_cache_set_fifo.f =====
rtl/core/cfs_pkg.sv
rtl/core/cfs_tag_dir.sv
rtl/core/cfs_data_mem.sv
rtl/core/four_way_cache_set_fifo.sv
tb/four_way_cache_set_fifo_tb.sv
